/* design/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// Skeleton spur pruner package
// Shared constants and types for the spur pruner block.
// ----------------------------------------------------------------------------
package ssp_pkg;

	localparam int MAX_EDGES_DEF   = 16;
	localparam int MAX_NODES_DEF   = 32;
	localparam int LENGTH_BITS_DEF = 20;

	localparam int SUM_W = 36;
	localparam int CNT_W = 16;
	localparam int RAD_W = 20;
	localparam int LEN_W = 20;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_NODE   = 2'd0,
		CMD_EDGE   = 2'd1,
		CMD_SAMPLE = 2'd2,
		CMD_RUN    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_REMOVED = 3'd0,
		KIND_NODE    = 3'd1,
		KIND_EDGE    = 3'd2,
		KIND_ORPHAN  = 3'd3,
		KIND_DONE    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		NT_ENDPOINT = 2'd0,
		NT_CONT     = 2'd1,
		NT_JUNCTION = 2'd2,
		NT_ISOLATED = 2'd3
	} node_type_t;

	localparam logic [1:0] REG_MIN_LEN  = 2'd0;
	localparam logic [1:0] REG_MAX_ITER = 2'd1;
	localparam logic [1:0] REG_RATIO    = 2'd2;

endpackage

/* design/ssp_short_test.sv */
// ----------------------------------------------------------------------------
// Spur length test
// Registered test: len<min_len, or samples>0 and len*samples*256<ratio*sum.
// ----------------------------------------------------------------------------
module ssp_short_test #(
	parameter int LENGTH_BITS = ssp_pkg::LENGTH_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     start,
	input  logic [LENGTH_BITS-1:0]   len,
	input  logic [ssp_pkg::CNT_W-1:0] cnt,
	input  logic [ssp_pkg::SUM_W-1:0] sum,
	input  logic [ssp_pkg::LEN_W-1:0] min_len,
	input  logic [15:0]              ratio,
	output logic                     is_short
);
	localparam int LP = LENGTH_BITS + ssp_pkg::CNT_W;
	localparam int RP = 16 + ssp_pkg::SUM_W;
	localparam int PW = (LP + 8 > RP) ? LP + 8 : RP;

	logic [LP-1:0] lp_q;
	logic [RP-1:0] rp_q;
	logic          min_q;
	logic          zero_q;

	always_ff @(posedge clk) begin
		if (start) begin
			lp_q   <= LP'(len) * LP'(cnt);
			rp_q   <= RP'(ratio) * RP'(sum);
			min_q  <= {{(PW-LENGTH_BITS){1'b0}}, len} < {{(PW-ssp_pkg::LEN_W){1'b0}}, min_len};
			zero_q <= (cnt == '0);
		end
	end

	assign is_short = min_q || (!zero_q && ({PW'(lp_q), 8'd0} < {8'd0, PW'(rp_q)}));
endmodule

/* design/skeleton_spur_pruner.sv */
// ----------------------------------------------------------------------------
// Skeleton spur pruner
// Loads a skeleton graph and prunes short terminal branches on a run request.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake
// in      | input     | in_valid / in_stall
// out     | output    | out_valid / out_stall
// cfg     | input     | cfg_valid / cfg_ready
// Load requests are accepted while idle; the input is stalled for the whole run.
// A pass is a degree sweep over the edges and a test sweep that judges each live
// edge with a degree-one endpoint, and one more degree sweep closes the passes.
// Reporting numbers the endpoints of kept edges, then lists the kept edges and
// the orphan nodes, then the done row and a clearing step; a stalled output holds
// the current step.
// ----------------------------------------------------------------------------
module skeleton_spur_pruner #(
	parameter int MAX_EDGES   = ssp_pkg::MAX_EDGES_DEF,
	parameter int MAX_NODES   = ssp_pkg::MAX_NODES_DEF,
	parameter int LENGTH_BITS = ssp_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [19:0] node_radius,
	input  logic [4:0]  from_node,
	input  logic [4:0]  to_node,
	input  logic [19:0] edge_len,
	input  logic [19:0] radius_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [4:0]  orig_index,
	output logic [4:0]  new_id,
	output logic [4:0]  from_node_res,
	output logic [4:0]  to_node_res,
	output logic [1:0]  node_type,
	output logic [19:0] edge_len_res,
	output logic [35:0] radius_sum,
	output logic [15:0] radius_samples,
	output logic [19:0] node_radius_res,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int NW = $clog2(MAX_NODES);
	localparam int EC = $clog2(MAX_EDGES + 1);
	localparam int NC = $clog2(MAX_NODES + 1);
	localparam int DW = $clog2(2 * MAX_EDGES + 1);
	localparam int IW = (EC > NC) ? EC : NC;

	localparam logic [1:0] REG_MIN_LEN_C = ssp_pkg::REG_MIN_LEN;
	localparam logic [1:0] REG_MAX_IT_C  = ssp_pkg::REG_MAX_ITER;
	localparam logic [1:0] REG_RATIO_C   = ssp_pkg::REG_RATIO;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_DEG   = 9'b000000010,
		ST_TEST  = 9'b000000100,
		ST_JUDGE = 9'b000001000,
		ST_NODES = 9'b000010000,
		ST_EDGES = 9'b000100000,
		ST_ORPH  = 9'b001000000,
		ST_DONE  = 9'b010000000,
		ST_FINAL = 9'b100000000
	} state_t;

	state_t state_q;
	logic [19:0] min_len_q;
	logic [7:0]  max_iter_q;
	logic [15:0] ratio_q;

	logic [NW-1:0]          e_from_q [MAX_EDGES];
	logic [NW-1:0]          e_to_q   [MAX_EDGES];
	logic [LENGTH_BITS-1:0] e_len_q  [MAX_EDGES];
	logic [35:0]            e_sum_q  [MAX_EDGES];
	logic [15:0]            e_cnt_q  [MAX_EDGES];
	logic [MAX_EDGES-1:0]   live_q;
	logic [19:0]            n_rad_q  [MAX_NODES];
	logic [DW-1:0]          deg_q    [MAX_NODES];
	logic [MAX_NODES-1:0]   nid_v_q;
	logic [4:0]             nid_q    [MAX_NODES];
	logic [EC-1:0]          edges_q;
	logic [NC-1:0]          nodes_q;
	logic [EC-1:0]          live_cnt_q;
	logic [IW-1:0]          idx_q;
	logic                   side_q;
	logic [7:0]             iter_q;
	logic                   changed_q;
	logic [5:0]             next_id_q;
	logic                   degclr_q;

	logic out_free;
	logic in_acc;
	logic short_w;
	logic [EW-1:0] ei;
	logic [NW-1:0] cur_n;

	assign out_free  = !out_valid || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign ei        = idx_q[EW-1:0];
	assign cur_n     = side_q ? e_to_q[ei] : e_from_q[ei];

	ssp_short_test #(.LENGTH_BITS(LENGTH_BITS)) u_test (
		.clk(clk), .start(state_q == ST_TEST),
		.len(e_len_q[ei]), .cnt(e_cnt_q[ei]), .sum(e_sum_q[ei]),
		.min_len(min_len_q), .ratio(ratio_q), .is_short(short_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q  <= '0;
			max_iter_q <= 8'd16;
			ratio_q    <= 16'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MIN_LEN_C: min_len_q <= cfg_data;
				REG_MAX_IT_C:  max_iter_q <= cfg_data[7:0];
				REG_RATIO_C:   ratio_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	function automatic logic [1:0] ntype(input logic [DW-1:0] d);
		if (d == DW'(1)) return ssp_pkg::NT_ENDPOINT;
		if (d == DW'(2)) return ssp_pkg::NT_CONT;
		if (d == '0)     return ssp_pkg::NT_ISOLATED;
		return ssp_pkg::NT_JUNCTION;
	endfunction

	always_ff @(posedge clk) begin
		if (in_acc && cmd == ssp_pkg::CMD_NODE && nodes_q < NC'(MAX_NODES))
			n_rad_q[nodes_q[NW-1:0]] <= node_radius;
		if (in_acc && cmd == ssp_pkg::CMD_EDGE && edges_q < EC'(MAX_EDGES)
				&& NC'(from_node) < nodes_q && NC'(to_node) < nodes_q) begin
			e_from_q[edges_q[EW-1:0]] <= NW'(from_node);
			e_to_q[edges_q[EW-1:0]]   <= NW'(to_node);
			e_len_q[edges_q[EW-1:0]]  <= LENGTH_BITS'(edge_len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic fire;
		fire = 1'b0;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			edges_q <= '0; nodes_q <= '0; live_cnt_q <= '0; live_q <= '0;
			nid_v_q <= '0; idx_q <= '0; side_q <= 1'b0; iter_q <= '0;
			changed_q <= 1'b0; next_id_q <= '0; degclr_q <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < MAX_EDGES; i++) begin
				e_sum_q[i] <= '0; e_cnt_q[i] <= '0;
			end
			for (int i = 0; i < MAX_NODES; i++) begin
				deg_q[i] <= '0; nid_q[i] <= '0;
			end
			kind <= '0; orig_index <= '0; new_id <= '0; from_node_res <= '0;
			to_node_res <= '0; node_type <= '0; edge_len_res <= '0;
			radius_sum <= '0; radius_samples <= '0; node_radius_res <= '0;
			last <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (cmd)
							ssp_pkg::CMD_NODE:
								if (nodes_q < NC'(MAX_NODES)) nodes_q <= nodes_q + 1'b1;
							ssp_pkg::CMD_EDGE:
								if (edges_q < EC'(MAX_EDGES) && NC'(from_node) < nodes_q
										&& NC'(to_node) < nodes_q) begin
									e_sum_q[edges_q[EW-1:0]] <= '0;
									e_cnt_q[edges_q[EW-1:0]] <= '0;
									edges_q <= edges_q + 1'b1;
								end
							ssp_pkg::CMD_SAMPLE:
								if (edges_q != '0) begin
									if (ssp_pkg::SUM_MAX - e_sum_q[EW'(edges_q - 1'b1)]
											< 36'(radius_sample))
										e_sum_q[EW'(edges_q - 1'b1)] <= ssp_pkg::SUM_MAX;
									else
										e_sum_q[EW'(edges_q - 1'b1)] <=
											e_sum_q[EW'(edges_q - 1'b1)] + 36'(radius_sample);
									if (e_cnt_q[EW'(edges_q - 1'b1)] != ssp_pkg::CNT_MAX)
										e_cnt_q[EW'(edges_q - 1'b1)] <=
											e_cnt_q[EW'(edges_q - 1'b1)] + 1'b1;
								end
							default: begin
								for (int i = 0; i < MAX_EDGES; i++)
									live_q[i] <= (EC'(i) < edges_q);
								live_cnt_q <= edges_q;
								iter_q <= '0; idx_q <= '0; changed_q <= 1'b0;
								degclr_q <= 1'b1; state_q <= ST_DEG;
							end
						endcase
					end
				end
				ST_DEG: begin
					if (degclr_q) begin
						for (int i = 0; i < MAX_NODES; i++) deg_q[i] <= '0;
						degclr_q <= 1'b0; idx_q <= '0;
					end else if (idx_q >= IW'(edges_q)) begin
						idx_q <= '0; changed_q <= 1'b0;
						if (iter_q < max_iter_q && live_cnt_q > EC'(1)) state_q <= ST_TEST;
						else begin state_q <= ST_NODES; side_q <= 1'b0; next_id_q <= '0; end
					end else begin
						if (live_q[ei]) begin
							if (e_from_q[ei] == e_to_q[ei])
								deg_q[e_from_q[ei]] <= deg_q[e_from_q[ei]] + DW'(2);
							else begin
								deg_q[e_from_q[ei]] <= deg_q[e_from_q[ei]] + 1'b1;
								deg_q[e_to_q[ei]]   <= deg_q[e_to_q[ei]] + 1'b1;
							end
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_TEST: begin
					if (idx_q >= IW'(edges_q)) begin
						iter_q <= iter_q + 1'b1;
						degclr_q <= 1'b1;
						if (changed_q) state_q <= ST_DEG;
						else begin
							iter_q <= max_iter_q;
							state_q <= ST_DEG;
						end
					end else if (!live_q[ei] || (deg_q[e_from_q[ei]] != DW'(1)
							&& deg_q[e_to_q[ei]] != DW'(1)))
						idx_q <= idx_q + 1'b1;
					else state_q <= ST_JUDGE;
				end
				ST_JUDGE: begin
					if (!short_w || live_cnt_q <= EC'(1)) begin
						idx_q <= idx_q + 1'b1; state_q <= ST_TEST;
					end else if (out_free) begin
						live_q[ei] <= 1'b0;
						live_cnt_q <= live_cnt_q - 1'b1;
						changed_q <= 1'b1;
						fire = 1'b1;
						kind <= ssp_pkg::KIND_REMOVED; orig_index <= 5'(idx_q);
						new_id <= '0; from_node_res <= '0; to_node_res <= '0;
						node_type <= '0; edge_len_res <= 20'(e_len_q[ei]);
						radius_sum <= e_sum_q[ei]; radius_samples <= e_cnt_q[ei];
						node_radius_res <= '0; last <= 1'b0;
						idx_q <= idx_q + 1'b1; state_q <= ST_TEST;
					end
				end
				ST_NODES: begin
					if (idx_q >= IW'(edges_q)) begin
						idx_q <= '0; next_id_q <= '0; state_q <= ST_EDGES;
					end else if (!live_q[ei] || nid_v_q[cur_n]) begin
						side_q <= !side_q;
						if (side_q) idx_q <= idx_q + 1'b1;
					end else if (out_free) begin
						nid_v_q[cur_n] <= 1'b1;
						nid_q[cur_n] <= next_id_q[4:0];
						fire = 1'b1;
						kind <= ssp_pkg::KIND_NODE; orig_index <= 5'(cur_n);
						new_id <= next_id_q[4:0]; from_node_res <= '0; to_node_res <= '0;
						node_type <= ntype(deg_q[cur_n]); edge_len_res <= '0;
						radius_sum <= '0; radius_samples <= '0;
						node_radius_res <= n_rad_q[cur_n]; last <= 1'b0;
						next_id_q <= next_id_q + 1'b1;
						side_q <= !side_q;
						if (side_q) idx_q <= idx_q + 1'b1;
					end
				end
				ST_EDGES: begin
					if (idx_q >= IW'(edges_q)) begin
						idx_q <= '0; state_q <= ST_ORPH;
					end else if (!live_q[ei]) idx_q <= idx_q + 1'b1;
					else if (out_free) begin
						fire = 1'b1;
						kind <= ssp_pkg::KIND_EDGE; orig_index <= 5'(idx_q);
						new_id <= next_id_q[4:0];
						from_node_res <= nid_q[e_from_q[ei]];
						to_node_res <= nid_q[e_to_q[ei]];
						node_type <= '0; edge_len_res <= 20'(e_len_q[ei]);
						radius_sum <= e_sum_q[ei]; radius_samples <= e_cnt_q[ei];
						node_radius_res <= '0; last <= 1'b0;
						next_id_q <= next_id_q + 1'b1;
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_ORPH: begin
					if (idx_q >= IW'(nodes_q))
						state_q <= ST_DONE;
					else if (nid_v_q[idx_q[NW-1:0]]) idx_q <= idx_q + 1'b1;
					else if (out_free) begin
						fire = 1'b1;
						kind <= ssp_pkg::KIND_ORPHAN; orig_index <= 5'(idx_q);
						new_id <= '0; from_node_res <= '0; to_node_res <= '0;
						node_type <= '0; edge_len_res <= '0; radius_sum <= '0;
						radius_samples <= '0; node_radius_res <= n_rad_q[idx_q[NW-1:0]];
						last <= 1'b0;
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						fire = 1'b1;
						kind <= ssp_pkg::KIND_DONE; orig_index <= '0; new_id <= '0;
						from_node_res <= '0; to_node_res <= '0; node_type <= '0;
						edge_len_res <= '0; radius_sum <= '0; radius_samples <= '0;
						node_radius_res <= '0; last <= 1'b1;
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					edges_q <= '0; nodes_q <= '0; live_cnt_q <= '0; live_q <= '0;
					nid_v_q <= '0; idx_q <= '0;
					for (int i = 0; i < MAX_EDGES; i++) begin
						e_sum_q[i] <= '0; e_cnt_q[i] <= '0;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			out_valid <= fire || (out_valid && out_stall);
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("input open during run");
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_cnt_q <= edges_q) else $error("live count exceeds edges");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (kind == ssp_pkg::KIND_DONE)) else $error("last off done");
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL) |=> (state_q == ST_IDLE && edges_q == '0))
		else $error("tables not cleared");
endmodule

/* tb/skeleton_spur_pruner_tb.sv */
// ----------------------------------------------------------------------------
// Skeleton spur pruner testbench
// Loads skeleton graphs, issues run requests and checks every reported row
// against an in-bench model of the pruning passes. A directed table covers
// empty runs, ignored loads and field extremes. Random graphs follow under
// several register settings, with random idling on both channels and one
// long output hold-off during a run.
// ----------------------------------------------------------------------------
module skeleton_spur_pruner_tb;
	import ssp_pkg::*;

	localparam int NE = 16;
	localparam int NN = 32;
	localparam int NONE_ID = 63;

	typedef struct {
		kind_t       kind;
		logic [4:0]  orig_index;
		logic [4:0]  new_id;
		logic [4:0]  from_res;
		logic [4:0]  to_res;
		node_type_t  ntype;
		logic [19:0] len;
		logic [35:0] rsum;
		logic [15:0] rcnt;
		logic [19:0] nrad;
		logic        last;
	} row_t;

	typedef struct {
		cmd_t        op;
		logic [19:0] nrad;
		logic [4:0]  from;
		logic [4:0]  to;
		logic [19:0] len;
		logic [19:0] smp;
		bit          typed_done;
	} stim_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] cmd = CMD_NODE;
	logic [19:0] node_radius = 0;
	logic [4:0] from_node = 0;
	logic [4:0] to_node = 0;
	logic [19:0] edge_len = 0;
	logic [19:0] radius_sample = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] kind;
	logic [4:0] orig_index, new_id, from_node_res, to_node_res;
	logic [1:0] node_type;
	logic [19:0] edge_len_res, node_radius_res;
	logic [35:0] radius_sum;
	logic [15:0] radius_samples;
	logic last;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_MIN_LEN;
	logic [19:0] cfg_data = 0;

	skeleton_spur_pruner dut (.*);

	always #5 clk = ~clk;

	// Model state.
	logic [19:0] m_min_len;
	logic [7:0] m_max_iter;
	logic [15:0] m_ratio;
	logic [4:0] e_from [NE];
	logic [4:0] e_to [NE];
	logic [19:0] e_len [NE];
	logic [35:0] e_sum [NE];
	logic [15:0] e_cnt [NE];
	bit e_live [NE];
	logic [19:0] n_rad [NN];
	int n_deg [NN];
	int n_id [NN];
	int edge_count, node_count, live_count;

	row_t pending_rows[$];
	row_t fresh_rows[$];
	int errors = 0;
	int items_sent = 0;
	int runs_done = 0;
	int rows_checked = 0;
	int pruned_seen = 0;
	bit quiet = 0;
	bit hold_req = 0;

	function automatic void add_fresh(row_t r);
		fresh_rows.insert(fresh_rows.size(), r);
	endfunction

	function automatic void clear_graph();
		for (int i = 0; i < NE; i++) begin
			e_sum[i] = 0;
			e_cnt[i] = 0;
			e_live[i] = 0;
		end
		for (int i = 0; i < NN; i++) begin
			n_deg[i] = 0;
			n_id[i] = NONE_ID;
		end
		edge_count = 0;
		node_count = 0;
		live_count = 0;
	endfunction

	function automatic void tally_degrees();
		for (int i = 0; i < NN; i++) n_deg[i] = 0;
		for (int i = 0; i < edge_count; i++) begin
			if (e_live[i]) begin
				n_deg[e_from[i]]++;
				n_deg[e_to[i]]++;
			end
		end
	endfunction

	function automatic row_t blank_row(kind_t k);
		row_t r;
		r.kind = k;
		r.orig_index = 0;
		r.new_id = 0;
		r.from_res = 0;
		r.to_res = 0;
		r.ntype = NT_ENDPOINT;
		r.len = 0;
		r.rsum = 0;
		r.rcnt = 0;
		r.nrad = 0;
		r.last = 0;
		return r;
	endfunction

	function automatic row_t edge_row(kind_t k, int i);
		row_t r;
		r = blank_row(k);
		r.orig_index = i[4:0];
		r.len = e_len[i];
		r.rsum = e_sum[i];
		r.rcnt = e_cnt[i];
		return r;
	endfunction

	function automatic bit spur_is_short(int i);
		logic [63:0] lhs, rhs;
		if (e_len[i] < m_min_len) return 1;
		if (e_cnt[i] == 0) return 0;
		lhs = 64'(e_len[i]) * 64'(e_cnt[i]) * 64'd256;
		rhs = 64'(m_ratio) * 64'(e_sum[i]);
		return lhs < rhs;
	endfunction

	function automatic void prune_and_report();
		bit changed;
		int next_node, next_edge, d, nid;
		row_t r;
		for (int i = 0; i < edge_count; i++) e_live[i] = 1;
		live_count = edge_count;
		for (int it = 0; it < m_max_iter && live_count > 1; it++) begin
			changed = 0;
			tally_degrees();
			for (int i = 0; i < edge_count; i++) begin
				if (!e_live[i]) continue;
				if (n_deg[e_from[i]] != 1 && n_deg[e_to[i]] != 1) continue;
				if (spur_is_short(i) && live_count > 1) begin
					e_live[i] = 0;
					live_count--;
					changed = 1;
					add_fresh(edge_row(KIND_REMOVED, i));
				end
			end
			if (!changed) break;
		end
		tally_degrees();
		next_node = 0;
		for (int i = 0; i < edge_count; i++) begin
			if (!e_live[i]) continue;
			for (int k = 0; k < 2; k++) begin
				nid = k ? e_to[i] : e_from[i];
				if (n_id[nid] != NONE_ID) continue;
				n_id[nid] = next_node;
				d = n_deg[nid];
				r = blank_row(KIND_NODE);
				r.orig_index = nid[4:0];
				r.new_id = next_node[4:0];
				r.ntype = d == 1 ? NT_ENDPOINT : d >= 3 ? NT_JUNCTION :
					d == 2 ? NT_CONT : NT_ISOLATED;
				r.nrad = n_rad[nid];
				add_fresh(r);
				next_node++;
			end
		end
		next_edge = 0;
		for (int i = 0; i < edge_count; i++) begin
			if (!e_live[i]) continue;
			r = edge_row(KIND_EDGE, i);
			r.new_id = next_edge[4:0];
			r.from_res = n_id[e_from[i]][4:0];
			r.to_res = n_id[e_to[i]][4:0];
			add_fresh(r);
			next_edge++;
		end
		for (int i = 0; i < node_count; i++) begin
			if (n_id[i] != NONE_ID) continue;
			r = blank_row(KIND_ORPHAN);
			r.orig_index = i[4:0];
			r.nrad = n_rad[i];
			add_fresh(r);
		end
		r = blank_row(KIND_DONE);
		r.last = 1;
		add_fresh(r);
		clear_graph();
	endfunction

	// Applies one accepted request to the model; run results land in fresh_rows.
	function automatic void apply_request(stim_t s);
		logic [35:0] gap_to_max;
		case (s.op)
			CMD_NODE: begin
				if (node_count < NN) begin
					n_rad[node_count] = s.nrad;
					node_count++;
				end
			end
			CMD_EDGE: begin
				if (edge_count < NE && s.from < node_count && s.to < node_count) begin
					e_from[edge_count] = s.from;
					e_to[edge_count] = s.to;
					e_len[edge_count] = s.len;
					e_sum[edge_count] = 0;
					e_cnt[edge_count] = 0;
					edge_count++;
				end
			end
			CMD_SAMPLE: begin
				if (edge_count > 0) begin
					gap_to_max = SUM_MAX - e_sum[edge_count-1];
					e_sum[edge_count-1] = gap_to_max < 36'(s.smp) ? SUM_MAX :
						e_sum[edge_count-1] + 36'(s.smp);
					if (e_cnt[edge_count-1] != CNT_MAX) e_cnt[edge_count-1]++;
				end
			end
			default: prune_and_report();
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
		errors++;
	endtask

	task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
		if (got !== want) report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin
		row_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rows.size() == 0) begin
				report_mismatch("unexpected result kind", 64'(kind), 64'hffff);
			end else begin
				w = pending_rows.pop_front();
				rows_checked++;
				if (w.kind == KIND_REMOVED) pruned_seen++;
				check_field("kind", kind, w.kind);
				check_field("orig_index", orig_index, w.orig_index);
				check_field("new_id", new_id, w.new_id);
				check_field("from_node_res", from_node_res, w.from_res);
				check_field("to_node_res", to_node_res, w.to_res);
				check_field("node_type", node_type, w.ntype);
				check_field("edge_len_res", edge_len_res, w.len);
				check_field("radius_sum", radius_sum, w.rsum);
				check_field("radius_samples", radius_samples, w.rcnt);
				check_field("node_radius_res", node_radius_res, w.nrad);
				check_field("last", last, w.last);
			end
		end
	end

	// Result receiver with random stalls and one long hold-off on request.
	initial begin
		int waits;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				out_stall <= 1;
				repeat (300) @(posedge clk);
			end
			waits = quiet ? 0 : $urandom_range(0, 17);
			if (waits > 0) begin
				out_stall <= 1;
				repeat (waits) @(posedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [19:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (idx)
			REG_MIN_LEN: m_min_len = val;
			REG_MAX_ITER: m_max_iter = val[7:0];
			default: m_ratio = val[15:0];
		endcase
	endtask

	task automatic configure(logic [19:0] min_len, logic [7:0] iters, logic [15:0] ratio);
		write_reg(REG_MIN_LEN, min_len);
		write_reg(REG_MAX_ITER, 20'(iters));
		write_reg(REG_RATIO, 20'(ratio));
	endtask

	task automatic send_request(stim_t s);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		cmd <= s.op;
		node_radius <= s.nrad;
		from_node <= s.from;
		to_node <= s.to;
		edge_len <= s.len;
		radius_sample <= s.smp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		apply_request(s);
		if (s.typed_done) begin
			fresh_rows.delete();
			add_fresh(blank_row(KIND_DONE));
			fresh_rows[0].last = 1;
		end
		if (s.op == CMD_RUN) runs_done++;
		while (fresh_rows.size() > 0)
			pending_rows.insert(pending_rows.size(), fresh_rows.pop_front());
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_rows.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic stim_t mk(cmd_t op, logic [19:0] nrad, logic [4:0] f, logic [4:0] t,
		logic [19:0] len, logic [19:0] smp, bit typed);
		stim_t s;
		s.op = op;
		s.nrad = nrad;
		s.from = f;
		s.to = t;
		s.len = len;
		s.smp = smp;
		s.typed_done = typed;
		return s;
	endfunction

	function automatic logic [19:0] pick_len();
		case ($urandom_range(0, 3))
			0: return 20'($urandom);
			1: return 20'($urandom_range(0, 4000));
			default: return 20'($urandom_range(0, 80));
		endcase
	endfunction

	initial begin
		stim_t plan [$];
		int nodes_in, edges_in, ph, pick;
		logic [4:0] f, t;
		m_min_len = 0;
		m_max_iter = 16;
		m_ratio = 256;
		clear_graph();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		configure(20'd0, 8'd16, 16'd256);
		plan = '{
			mk(CMD_RUN, 0, 0, 0, 0, 0, 1),
			mk(CMD_SAMPLE, 0, 0, 0, 0, 20'hfffff, 0),
			mk(CMD_NODE, 20'd0, 0, 0, 0, 0, 0),
			mk(CMD_NODE, 20'hfffff, 0, 0, 0, 0, 0),
			mk(CMD_NODE, 20'd100, 0, 0, 0, 0, 0),
			mk(CMD_NODE, 20'd7, 0, 0, 0, 0, 0),
			mk(CMD_EDGE, 0, 5'd0, 5'd31, 20'd5, 0, 0),
			mk(CMD_EDGE, 0, 5'd0, 5'd1, 20'd0, 0, 0),
			mk(CMD_EDGE, 0, 5'd1, 5'd2, 20'hfffff, 0, 0),
			mk(CMD_SAMPLE, 0, 0, 0, 0, 20'd3, 0),
			mk(CMD_SAMPLE, 0, 0, 0, 0, 20'hfffff, 0),
			mk(CMD_EDGE, 0, 5'd2, 5'd3, 20'd10, 0, 0),
			mk(CMD_SAMPLE, 0, 0, 0, 0, 20'd2000, 0),
			mk(CMD_EDGE, 0, 5'd3, 5'd3, 20'd1, 0, 0),
			mk(CMD_RUN, 0, 0, 0, 0, 0, 0),
			mk(CMD_NODE, 20'd5, 0, 0, 0, 0, 0),
			mk(CMD_NODE, 20'd6, 0, 0, 0, 0, 0),
			mk(CMD_EDGE, 0, 5'd1, 5'd0, 20'd50, 0, 0),
			mk(CMD_RUN, 0, 0, 0, 0, 0, 0),
			mk(CMD_RUN, 0, 0, 0, 0, 0, 1)
		};
		foreach (plan[i]) send_request(plan[i]);
		drain();

		ph = 0;
		while (items_sent < 240) begin
			case (ph % 5)
				0: configure(20'd0, 8'd16, 16'd256);
				1: configure(20'hfffff, 8'd255, 16'hffff);
				2: configure(20'd0, 8'd0, 16'd0);
				3: configure(20'($urandom), 8'd1, 16'($urandom));
				default: configure(20'($urandom_range(0, 100)), 8'($urandom_range(1, 8)),
					16'($urandom));
			endcase
			quiet = (ph % 4 == 3);
			if ($urandom_range(0, 5) == 0) begin
				nodes_in = 34;
				edges_in = 18;
			end else begin
				nodes_in = $urandom_range(1, 10);
				edges_in = $urandom_range(0, nodes_in + 2);
			end
			for (int i = 0; i < nodes_in; i++)
				send_request(mk(CMD_NODE, 20'($urandom), 0, 0, 0, 0, 0));
			for (int i = 0; i < edges_in; i++) begin
				pick = nodes_in > 32 ? 32 : nodes_in;
				if ($urandom_range(0, 1) && i > 0 && i < pick) begin
					f = 5'(i);
					t = 5'($urandom_range(0, i - 1));
				end else begin
					f = 5'($urandom_range(0, pick - 1));
					t = 5'($urandom_range(0, pick - 1));
				end
				if ($urandom_range(0, 11) == 0) t = 5'($urandom);
				send_request(mk(CMD_EDGE, 0, f, t, pick_len(), 0, 0));
				repeat ($urandom_range(0, 3))
					send_request(mk(CMD_SAMPLE, 0, 0, 0, 0,
						$urandom_range(0, 1) ? 20'($urandom) : 20'($urandom_range(0, 60)),
						0));
				if ($urandom_range(0, 15) == 0)
					send_request(mk(cmd_t'($urandom_range(0, 2)), 20'($urandom),
						5'($urandom), 5'($urandom), 20'($urandom), 20'($urandom), 0));
			end
			if (ph == 2) hold_req = 1;
			send_request(mk(CMD_RUN, 0, 0, 0, 0, 0, 0));
			if (ph == 2) send_request(mk(CMD_NODE, 20'($urandom), 0, 0, 0, 0, 0));
			drain();
			ph++;
		end

		$display("covered %0d run requests over %0d random phases and a directed table",
			runs_done, ph);
		$display("checked %0d result rows, %0d of them pruned edges", rows_checked,
			pruned_seen);
		if (errors == 0) begin
			$display("skeleton_spur_pruner_tb: done, clean");
		end else begin
			$display("skeleton_spur_pruner_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("timeout with %0d results still expected", pending_rows.size());
		$display("skeleton_spur_pruner_tb: done, errors");
		$finish;
	end

endmodule
